// ===== hdl/assert_macros.svh =====
// Assertion helpers for the checker file hpsc_chk.sv.
// Both check on the rising edge of clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check only while out of reset.
`define HPSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every edge, reset included.
`define HPSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/hpsc_pkg.sv =====
`timescale 1ns / 1ps
package hpsc_pkg;

  // Field widths
  localparam int TEMP_W    = 10;
  localparam int SP_HALF_W = 11;
  localparam int SP_DEG_W  = 10;
  localparam int PWR_W     = 7;
  localparam int STATE_W   = 8;
  localparam int WORK_W    = 10;
  localparam int ERR_W     = 12;
  localparam int RELOAD_W  = 16;
  localparam int TICK_W    = 2;

  // Divider widths: error * 100 over set point / 5
  localparam int DVD_W  = 19;
  localparam int DVS_W  = 9;
  localparam int QCNT_W = 5;

  // floor(sp / 5) as (sp * 6554) >> 15, exact for sp below 2048
  localparam int DEN_RECIP  = 6554;
  localparam int DEN_SHIFT  = 15;
  localparam int DEN_PROD_W = DEN_SHIFT + DVS_W;

  // APB register file
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  // Regulation constants
  localparam int GAIN_MUL   = 100;
  localparam int FAR_BAND   = 5;
  localparam int NEAR_BAND  = 3;
  localparam int SLEW_STEP  = 5;
  localparam int TRIM_STEP  = 3;
  localparam int PWR_MAX    = 99;
  localparam int PWR_MIN    = 15;
  localparam int PWR_HOT    = 93;
  localparam int Q_SAT      = 255;
  localparam int TICK_FULL  = 3;

  localparam logic [RELOAD_W-1:0] RELOAD_HOT  = 16'hFFFF - 16'h0258;
  localparam logic [RELOAD_W-1:0] RELOAD_BASE = 16'hFFFF - 16'd10000;
  localparam logic [RELOAD_W-1:0] RELOAD_STEP = 16'd100;

  // Register reset values
  localparam logic [SP_HALF_W-1:0] RST_SP_HALF = 11'd200;
  localparam logic [SP_DEG_W-1:0]  RST_SP_DEG  = 10'd100;
  localparam logic [PWR_W-1:0]     RST_FAULT   = 7'd15;

  typedef enum logic [2:0] {
    REG_MANUAL_MODE  = 3'd0,
    REG_SP_HALF      = 3'd1,
    REG_SP_DEG       = 3'd2,
    REG_SENSOR_POWER = 3'd3,
    REG_LOW_POWER    = 3'd4,
    REG_HIGH_POWER   = 3'd5,
    REG_MANUAL_POWER = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_POST,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                 manual_mode;
    logic [SP_HALF_W-1:0] set_point_half_deg;
    logic [SP_DEG_W-1:0]  set_point_deg;
    logic [PWR_W-1:0]     sensor_fault_power;
    logic [PWR_W-1:0]     low_fault_power;
    logic [PWR_W-1:0]     high_fault_power;
    logic [PWR_W-1:0]     manual_power;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_res_t;

endpackage

// ===== hdl/hpsc_cfg.sv =====
`timescale 1ns / 1ps
module hpsc_cfg
  import hpsc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  // Update the addressed register on the access beat
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_MANUAL_MODE:  cfg_nxt.manual_mode        = pwdata[0];
        REG_SP_HALF:      cfg_nxt.set_point_half_deg = pwdata[SP_HALF_W-1:0];
        REG_SP_DEG:       cfg_nxt.set_point_deg      = pwdata[SP_DEG_W-1:0];
        REG_SENSOR_POWER: cfg_nxt.sensor_fault_power = pwdata[PWR_W-1:0];
        REG_LOW_POWER:    cfg_nxt.low_fault_power    = pwdata[PWR_W-1:0];
        REG_HIGH_POWER:   cfg_nxt.high_fault_power   = pwdata[PWR_W-1:0];
        REG_MANUAL_POWER: cfg_nxt.manual_power       = pwdata[PWR_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.manual_mode        <= 1'b0;
      cfg_r.set_point_half_deg <= RST_SP_HALF;
      cfg_r.set_point_deg      <= RST_SP_DEG;
      cfg_r.sensor_fault_power <= RST_FAULT;
      cfg_r.low_fault_power    <= RST_FAULT;
      cfg_r.high_fault_power   <= RST_FAULT;
      cfg_r.manual_power       <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Return the addressed register
  always_comb begin
    unique case (idx)
      REG_MANUAL_MODE:  prdata = PDATA_W'(cfg_r.manual_mode);
      REG_SP_HALF:      prdata = PDATA_W'(cfg_r.set_point_half_deg);
      REG_SP_DEG:       prdata = PDATA_W'(cfg_r.set_point_deg);
      REG_SENSOR_POWER: prdata = PDATA_W'(cfg_r.sensor_fault_power);
      REG_LOW_POWER:    prdata = PDATA_W'(cfg_r.low_fault_power);
      REG_HIGH_POWER:   prdata = PDATA_W'(cfg_r.high_fault_power);
      REG_MANUAL_POWER: prdata = PDATA_W'(cfg_r.manual_power);
      default:          prdata = '0;
    endcase
  end

endmodule

// ===== hdl/hpsc_div.sv =====
`timescale 1ns / 1ps
module hpsc_div
  import hpsc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_res_t res
);

  logic [DVD_W-1:0]  quo_r, quo_nxt;
  logic [DVS_W-1:0]  rem_r, rem_nxt;
  logic [DVS_W-1:0]  dvs_r, dvs_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DVS_W:0]    trial;
  logic [DVS_W:0]    diff;

  // One restoring step per cycle: shift in a dividend bit, try the subtract
  assign trial = {rem_r, quo_r[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      cnt_nxt  = QCNT_W'(DVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = diff[DVS_W-1:0];
        quo_nxt = {quo_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DVS_W-1:0];
        quo_nxt = {quo_r[DVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - QCNT_W'(1);
      if (cnt_r == QCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign res.done     = done_r;
  assign res.quotient = quo_r;

endmodule

// ===== hdl/heater_power_slew_controller.sv =====
// Each input beat goes through the prepare step, then the shift-subtract divider when the power
// is recomputed, then the post and output steps, before its result enters the output register.
// One item at a time: no new input is taken until the result is loaded into the output register.
// A finished result waits in the output register while the next item is taken.
// Reset (rst_n low, synchronous): registers to defaults, power and tick state to zero.
`timescale 1ns / 1ps
module heater_power_slew_controller
  import hpsc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [TEMP_W-1:0]   in_temp_whole,
  input  logic                in_temp_half,
  input  logic                in_temp_negative,
  input  logic                in_alarm_sensor,
  input  logic                in_alarm_low,
  input  logic                in_alarm_high,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [PWR_W-1:0]    out_power_percent,
  output logic [RELOAD_W-1:0] out_timer_reload
);

  cfg_t     cfg;
  div_req_t div_req;
  div_res_t div_res;
  state_t   state_r, state_nxt;

  // Captured input beat
  logic [TEMP_W-1:0] temp_r;
  logic half_r, neg_r, a_sen_r, a_low_r, a_high_r;

  // Decisions taken in the prepare step
  logic far5_r, far3_r, above_r, below_r, den0_r;
  logic far5, far3, den0, recalc, alarm;

  // Regulation state
  logic [STATE_W-1:0] power_now_r, power_now_nxt;
  logic [STATE_W-1:0] power_prev_r, power_prev_nxt;
  logic [TICK_W-1:0]  tick_r, tick_nxt;

  // Output register
  logic                out_valid_r, out_valid_nxt;
  logic [PWR_W-1:0]    out_power_r;
  logic [RELOAD_W-1:0] out_reload_r, reload_calc;

  // Prepare-step datapath
  logic [SP_HALF_W-1:0]  tm;
  logic [ERR_W-1:0]      err;
  logic [DVD_W-1:0]      err100;
  logic [DEN_PROD_W-1:0] den_prod;
  logic [DVS_W-1:0]      den;
  logic [TEMP_W:0]       t_ext, spd_ext;

  // Post-step datapath
  logic [WORK_W-1:0] qsat, p0, pv0, p1, pv1, pc;
  logic [TICK_W-1:0] tick1;

  logic in_beat, out_load;

  hpsc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hpsc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .res   (div_res)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign in_beat  = in_valid && in_ready;
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (in_beat) begin
      temp_r   <= in_temp_whole;
      half_r   <= in_temp_half;
      neg_r    <= in_temp_negative;
      a_sen_r  <= in_alarm_sensor;
      a_low_r  <= in_alarm_low;
      a_high_r <= in_alarm_high;
    end
  end

  // Error in half degrees, gain divisor and band tests
  always_comb begin
    tm = {temp_r, half_r};
    if (neg_r) begin
      err = ERR_W'(cfg.set_point_half_deg) + ERR_W'(tm);
    end else if (tm > cfg.set_point_half_deg) begin
      err = '0;
    end else begin
      err = ERR_W'(cfg.set_point_half_deg - tm);
    end
    err100   = DVD_W'(err) * DVD_W'(GAIN_MUL);
    den_prod = DEN_PROD_W'(cfg.set_point_half_deg) * DEN_PROD_W'(DEN_RECIP);
    den      = den_prod[DEN_SHIFT +: DVS_W];
    den0     = (den == '0);
    t_ext    = {1'b0, temp_r};
    spd_ext  = {1'b0, cfg.set_point_deg};
    far5     = (t_ext + (TEMP_W+1)'(FAR_BAND) < spd_ext) ||
               (spd_ext + (TEMP_W+1)'(FAR_BAND) < t_ext);
    far3     = (t_ext + (TEMP_W+1)'(NEAR_BAND) < spd_ext) ||
               (spd_ext + (TEMP_W+1)'(NEAR_BAND) < t_ext);
    alarm    = a_sen_r || a_low_r || a_high_r;
    recalc   = !cfg.manual_mode && !alarm && far5;
  end

  assign div_req.start    = (state_r == ST_PREP) && recalc && !den0;
  assign div_req.dividend = err100;
  assign div_req.divisor  = den;

  always_ff @(posedge clk) begin
    if (state_r == ST_PREP) begin
      far5_r  <= far5;
      far3_r  <= far3;
      above_r <= (temp_r > cfg.set_point_deg);
      below_r <= (temp_r < cfg.set_point_deg);
      den0_r  <= den0;
    end
  end

  // Select, slew or trim, then clamp; manual mode takes the manual power as it is
  always_comb begin
    if (den0_r || (div_res.quotient > DVD_W'(Q_SAT))) begin
      qsat = WORK_W'(Q_SAT);
    end else begin
      qsat = WORK_W'(div_res.quotient[STATE_W-1:0]);
    end
    tick1 = (tick_r == TICK_W'(TICK_FULL)) ? tick_r : tick_r + TICK_W'(1);

    pv0 = WORK_W'(power_prev_r);
    if (a_sen_r) begin
      p0 = WORK_W'(cfg.sensor_fault_power);
    end else if (a_high_r) begin
      p0 = WORK_W'(cfg.high_fault_power);
    end else if (a_low_r) begin
      p0 = WORK_W'(cfg.low_fault_power);
    end else if (far5_r) begin
      p0  = qsat;
      pv0 = WORK_W'(power_now_r);
    end else begin
      p0 = WORK_W'(power_now_r);
    end

    p1       = p0;
    pv1      = pv0;
    tick_nxt = tick1;
    if (far3_r) begin
      if (p0 > pv0 + WORK_W'(SLEW_STEP)) begin
        pv1      = pv0 + WORK_W'(SLEW_STEP);
        p1       = pv1;
        tick_nxt = '0;
      end else if (pv0 > p0 + WORK_W'(SLEW_STEP)) begin
        pv1      = pv0 - WORK_W'(SLEW_STEP);
        p1       = pv1;
        tick_nxt = '0;
      end
    end else if (tick1 == TICK_W'(TICK_FULL)) begin
      if (above_r) begin
        p1       = (p0 < WORK_W'(TRIM_STEP)) ? '0 : p0 - WORK_W'(TRIM_STEP);
        pv1      = p1;
        tick_nxt = '0;
      end else if (below_r) begin
        p1       = p0 + WORK_W'(TRIM_STEP);
        pv1      = p1;
        tick_nxt = '0;
      end
    end

    if (p1 > WORK_W'(PWR_MAX)) begin
      pc = WORK_W'(PWR_MAX);
    end else if (p1 < WORK_W'(PWR_MIN)) begin
      pc = WORK_W'(PWR_MIN);
    end else begin
      pc = p1;
    end

    // Manual mode leaves previous power and tick untouched
    if (cfg.manual_mode) begin
      power_now_nxt  = STATE_W'(cfg.manual_power);
      power_prev_nxt = power_prev_r;
      tick_nxt       = tick_r;
    end else begin
      power_now_nxt  = pc[STATE_W-1:0];
      power_prev_nxt = pv1[STATE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      power_now_r  <= '0;
      power_prev_r <= '0;
      tick_r       <= '0;
    end else if (state_r == ST_POST) begin
      power_now_r  <= power_now_nxt;
      power_prev_r <= power_prev_nxt;
      tick_r       <= tick_nxt;
    end
  end

  // Firing timer reload from the final power
  always_comb begin
    if (power_now_r > STATE_W'(PWR_HOT)) begin
      reload_calc = RELOAD_HOT;
    end else begin
      reload_calc = RELOAD_BASE + RELOAD_W'(power_now_r) * RELOAD_STEP;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_beat) state_nxt = ST_PREP;
      ST_PREP: state_nxt = div_req.start ? ST_DIV : ST_POST;
      ST_DIV:  if (div_res.done) state_nxt = ST_POST;
      ST_POST: state_nxt = ST_OUT;
      ST_OUT:  if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Hold the result until the output beat
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_power_r  <= power_now_r[PWR_W-1:0];
      out_reload_r <= reload_calc;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_power_percent = out_power_r;
  assign out_timer_reload  = out_reload_r;

endmodule

// ===== hdl/hpsc_chk.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module hpsc_chk
  import hpsc_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                psel,
  input logic                penable,
  input logic                pwrite,
  input logic [PADDR_W-1:0]  paddr,
  input logic [PDATA_W-1:0]  pwdata,
  input logic [PDATA_W-1:0]  prdata,
  input logic                pready,
  input logic                in_valid,
  input logic                in_ready,
  input logic [TEMP_W-1:0]   in_temp_whole,
  input logic                in_temp_half,
  input logic                in_temp_negative,
  input logic                in_alarm_sensor,
  input logic                in_alarm_low,
  input logic                in_alarm_high,
  input logic                out_valid,
  input logic                out_ready,
  input logic [PWR_W-1:0]    out_power_percent,
  input logic [RELOAD_W-1:0] out_timer_reload
);

  // A stalled result holds
  `HPSC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_power_percent) && $stable(out_timer_reload), "result changed while stalled")

  // One item at a time: no input beat right after one is taken
  `HPSC_ASSERT(a_one_item, in_valid && in_ready |=> !in_ready, "input taken while busy")

  // Reload follows the delivered power
  `HPSC_ASSERT(a_reload_hot, out_valid && out_power_percent > 7'd93 |-> out_timer_reload == RELOAD_HOT, "hot reload mismatch")
  `HPSC_ASSERT(a_reload_lin, out_valid && out_power_percent <= 7'd93 |-> out_timer_reload == RELOAD_BASE + RELOAD_W'(out_power_percent) * RELOAD_STEP, "reload mismatch")

  // Reset empties the output register
  `HPSC_ASSERT_ALWAYS(a_rst_out, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind heater_power_slew_controller hpsc_chk u_hpsc_chk (.*);

// ===== tb/sv/power_checker.sv =====
`timescale 1ns / 1ps
module power_checker
  import hpsc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [TEMP_W-1:0]   in_temp_whole,
  input  logic                in_temp_half,
  input  logic                in_temp_negative,
  input  logic                in_alarm_sensor,
  input  logic                in_alarm_low,
  input  logic                in_alarm_high,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [PWR_W-1:0]    out_power_percent,
  input  logic [RELOAD_W-1:0] out_timer_reload,
  output int                  mismatches,
  output int                  results_seen,
  output int                  results_due
);

  typedef struct packed {
    logic [PWR_W-1:0]    power;
    logic [RELOAD_W-1:0] reload;
  } power_result_t;

  // Register mirror, updated from observed write beats
  cfg_t cfg;

  // Regulation state
  int heat_now;
  int heat_prev;
  int tick_count;

  power_result_t power_due[$];
  power_result_t want;

  // Firing delay shrinks with power; above the hot limit it is fixed
  function automatic logic [RELOAD_W-1:0] reload_for(input int p);
    int delay;
    if (p > PWR_HOT) begin
      delay = 'h0258;
    end else begin
      delay = 10000 - GAIN_MUL * p;
    end
    return RELOAD_W'('hFFFF - delay);
  endfunction

  // Advance the regulation state by one reading and return the result beat
  function automatic power_result_t predict_power(input logic [TEMP_W-1:0] whole,
                                                  input logic half, input logic neg,
                                                  input logic sen, input logic low,
                                                  input logic high);
    int t;
    int spd;
    int sp;
    int tm;
    int err;
    int den;
    int q;
    power_result_t res;
    t   = whole;
    spd = cfg.set_point_deg;
    sp  = cfg.set_point_half_deg;
    if (cfg.manual_mode) begin
      // Manual power passes unclamped; previous power and ticks hold
      heat_now = cfg.manual_power;
    end else begin
      if (tick_count < TICK_FULL) begin
        tick_count++;
      end
      // Alarms force power: sensor first, then high over low
      if (sen) begin
        heat_now = cfg.sensor_fault_power;
      end else if (high) begin
        heat_now = cfg.high_fault_power;
      end else if (low) begin
        heat_now = cfg.low_fault_power;
      end else begin
        tm = 2 * t + int'(half);
        if (neg) begin
          err = sp + tm;
        end else if (tm > sp) begin
          err = 0;
        end else begin
          err = sp - tm;
        end
        // Far from target: recompute power from the error, saturate at the top
        if (spd - FAR_BAND > t || spd + FAR_BAND < t) begin
          den = 20 * sp / 100;
          heat_prev = heat_now;
          if (den == 0) begin
            q = Q_SAT;
          end else begin
            q = err * GAIN_MUL / den;
          end
          heat_now = (q > Q_SAT) ? Q_SAT : q;
        end
      end
      if (spd - NEAR_BAND > t || spd + NEAR_BAND < t) begin
        // Outside the near band: slew toward the new power
        if (heat_now > heat_prev && heat_now - heat_prev > SLEW_STEP) begin
          heat_prev  = heat_prev + SLEW_STEP;
          heat_now   = heat_prev;
          tick_count = 0;
        end
        if (heat_now < heat_prev && heat_prev - heat_now > SLEW_STEP) begin
          heat_prev  = heat_prev - SLEW_STEP;
          heat_now   = heat_prev;
          tick_count = 0;
        end
      end else begin
        // Inside the near band: trim once the tick count is full
        if (t > spd && tick_count > 2) begin
          heat_now = heat_now - TRIM_STEP;
          if (heat_now < 0) begin
            heat_now = 0;
          end
          heat_prev  = heat_now;
          tick_count = 0;
        end
        if (t < spd && tick_count > 2) begin
          heat_now   = heat_now + TRIM_STEP;
          heat_prev  = heat_now;
          tick_count = 0;
        end
      end
      if (heat_now > PWR_MAX) begin
        heat_now = PWR_MAX;
      end
      if (heat_now < PWR_MIN) begin
        heat_now = PWR_MIN;
      end
    end
    res.power  = heat_now[PWR_W-1:0];
    res.reload = reload_for(heat_now);
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      // Drop the register mirror, regulation state and pending results back to defaults
      cfg.manual_mode        = 1'b0;
      cfg.set_point_half_deg = RST_SP_HALF;
      cfg.set_point_deg      = RST_SP_DEG;
      cfg.sensor_fault_power = RST_FAULT;
      cfg.low_fault_power    = RST_FAULT;
      cfg.high_fault_power   = RST_FAULT;
      cfg.manual_power       = '0;
      heat_now   = 0;
      heat_prev  = 0;
      tick_count = 0;
      power_due.delete();
      results_due = 0;
    end else begin
      // Compare a result beat against the oldest expectation
      if (out_valid && out_ready) begin
        results_seen++;
        if (power_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result beat, power %0d reload 0x%04h", $time,
                   out_power_percent, out_timer_reload);
        end else begin
          want = power_due.pop_front();
          if (out_power_percent !== want.power) begin
            mismatches++;
            $display("%0t: power_percent expected %0d, got %0d", $time,
                     want.power, out_power_percent);
          end
          if (out_timer_reload !== want.reload) begin
            mismatches++;
            $display("%0t: timer_reload expected 0x%04h, got 0x%04h", $time,
                     want.reload, out_timer_reload);
          end
        end
      end

      // Track register writes
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[PADDR_W-1:2]))
          REG_MANUAL_MODE:  cfg.manual_mode        = pwdata[0];
          REG_SP_HALF:      cfg.set_point_half_deg = pwdata[SP_HALF_W-1:0];
          REG_SP_DEG:       cfg.set_point_deg      = pwdata[SP_DEG_W-1:0];
          REG_SENSOR_POWER: cfg.sensor_fault_power = pwdata[PWR_W-1:0];
          REG_LOW_POWER:    cfg.low_fault_power    = pwdata[PWR_W-1:0];
          REG_HIGH_POWER:   cfg.high_fault_power   = pwdata[PWR_W-1:0];
          REG_MANUAL_POWER: cfg.manual_power       = pwdata[PWR_W-1:0];
          default: ;
        endcase
      end

      // Predict the result of an accepted reading
      if (in_valid && in_ready) begin
        power_due.push_back(predict_power(in_temp_whole, in_temp_half, in_temp_negative,
                                          in_alarm_sensor, in_alarm_low, in_alarm_high));
      end
      results_due = power_due.size();
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import hpsc_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 53;
  localparam int RANDOM_SET  = 6;

  typedef enum {DRAIN_FREE, DRAIN_COIN, DRAIN_SPARSE} drain_mode_t;

  typedef struct {
    logic [TEMP_W-1:0] whole;
    logic              half;
    logic              neg;
    logic              sen;
    logic              low;
    logic              high;
  } reading_t;

  logic                clk;
  logic                rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  logic                in_valid;
  logic                in_ready;
  logic [TEMP_W-1:0]   in_temp_whole;
  logic                in_temp_half;
  logic                in_temp_negative;
  logic                in_alarm_sensor;
  logic                in_alarm_low;
  logic                in_alarm_high;
  logic                out_valid;
  logic                out_ready;
  logic [PWR_W-1:0]    out_power_percent;
  logic [RELOAD_W-1:0] out_timer_reload;

  int mismatches;
  int results_seen;
  int results_due;
  int readings_sent;
  int directed_sent;
  int reg_writes;
  int settings_used;
  int burst_left;
  int idle_cycles;
  int cur_sp_deg;
  bit long_hold_done;
  drain_mode_t drain_mode;
  reading_t rd;

  // Register settings per phase: mode, half-degree and whole-degree set points,
  // sensor, low and high fault power, manual power
  int unsigned phase_cfg[PHASES][7] = '{
    '{0, 200, 100, 0, 99, 50, 0},
    '{0, 10, 0, 99, 0, 15, 100},
    '{0, 1998, 999, 15, 99, 0, 37},
    '{1, 1998, 999, 15, 99, 0, 100},
    '{1, 200, 100, 0, 0, 0, 0},
    '{0, 4, 2, 33, 66, 99, 50},
    '{0, 0, 0, 0, 0, 0, 0},
    '{0, 600, 300, 99, 99, 99, 100}
  };

  heater_power_slew_controller dut (.*);

  power_checker checker_i (.*);

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Write one register through a setup and an access cycle
  task automatic write_reg(input reg_idx_t idx, input int unsigned value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    reg_writes++;
  endtask

  // Offer one reading and hold it until the beat is taken
  task automatic offer(input logic [TEMP_W-1:0] whole, input logic half, input logic neg,
                       input logic sen, input logic low, input logic high);
    @(negedge clk);
    in_valid         <= 1'b1;
    in_temp_whole    <= whole;
    in_temp_half     <= half;
    in_temp_negative <= neg;
    in_alarm_sensor  <= sen;
    in_alarm_low     <= low;
    in_alarm_high    <= high;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    readings_sent++;
  endtask

  // Drop valid and wait for every pending result
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
  endtask

  // Insert a random gap at the start of each burst
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 10);
    end
    burst_left--;
  endtask

  // Mostly readings around the set point, with far, extreme and negative ones mixed in
  function automatic reading_t random_reading(input int spd);
    reading_t r;
    int pick;
    int w;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      w = spd + int'($urandom_range(0, 16)) - 8;
    end else if (pick < 70) begin
      w = $urandom_range(0, 999);
    end else if (pick < 80) begin
      w = $urandom_range(0, 1) ? 999 - int'($urandom_range(0, 2)) : $urandom_range(0, 3);
    end else begin
      w = spd + int'($urandom_range(0, 80)) - 40;
    end
    if (w < 0) begin
      w = 0;
    end
    if (w > 999) begin
      w = 999;
    end
    r.whole = w[TEMP_W-1:0];
    r.half  = 1'($urandom_range(0, 1));
    r.neg   = ($urandom_range(0, 5) == 0);
    r.sen   = ($urandom_range(0, 11) == 0);
    r.low   = ($urandom_range(0, 11) == 0);
    r.high  = ($urandom_range(0, 11) == 0);
    return r;
  endfunction

  // Result side: stall on random patterns, hold off once for a long stretch
  initial begin
    out_ready = 1'b0;
    forever begin
      drain_mode = drain_mode_t'($urandom_range(0, 2));
      repeat ($urandom_range(20, 80)) begin
        @(negedge clk);
        case (drain_mode)
          DRAIN_FREE:   out_ready <= 1'b1;
          DRAIN_COIN:   out_ready <= 1'($urandom_range(0, 1));
          DRAIN_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
          default:      out_ready <= 1'b1;
        endcase
      end
      if (!long_hold_done && readings_sent >= 150) begin
        long_hold_done = 1'b1;
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          out_ready <= 1'b0;
        end
      end
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout, no beat for %0d cycles", $time, IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n            = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_valid         = 1'b0;
    in_temp_whole    = '0;
    in_temp_half     = 1'b0;
    in_temp_negative = 1'b0;
    in_alarm_sensor  = 1'b0;
    in_alarm_low     = 1'b0;
    in_alarm_high    = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed readings at the reset settings: extremes, band edges, alarms
    offer(0, 0, 0, 0, 0, 0);
    offer(999, 1, 0, 0, 0, 0);
    offer(999, 1, 1, 0, 0, 0);
    offer(0, 1, 1, 0, 0, 0);
    offer(100, 0, 0, 0, 0, 0);
    offer(97, 0, 0, 0, 0, 0);
    offer(103, 1, 0, 0, 0, 0);
    offer(95, 0, 0, 0, 0, 0);
    offer(105, 0, 0, 0, 0, 0);
    offer(94, 1, 0, 0, 0, 0);
    offer(106, 0, 0, 0, 0, 0);
    offer(100, 0, 0, 1, 0, 0);
    offer(100, 0, 0, 0, 1, 0);
    offer(100, 0, 0, 0, 0, 1);
    offer(100, 0, 0, 0, 1, 1);
    offer(100, 0, 0, 1, 1, 1);
    // Trim down, then up, once the tick count fills
    repeat (3) offer(101, 0, 0, 0, 0, 0);
    repeat (3) offer(99, 1, 0, 0, 0, 0);
    settle();
    // Trim below zero under a zero forced power
    write_reg(REG_HIGH_POWER, 0);
    repeat (4) offer(101, 1, 0, 0, 0, 1);
    settle();
    directed_sent = readings_sent;

    // Random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      if (p == RANDOM_SET) begin
        phase_cfg[p][REG_SP_DEG]       = $urandom_range(20, 900);
        phase_cfg[p][REG_SP_HALF]      = 2 * phase_cfg[p][REG_SP_DEG] + $urandom_range(0, 1);
        phase_cfg[p][REG_SENSOR_POWER] = $urandom_range(0, 99);
        phase_cfg[p][REG_LOW_POWER]    = $urandom_range(0, 99);
        phase_cfg[p][REG_HIGH_POWER]   = $urandom_range(0, 99);
        phase_cfg[p][REG_MANUAL_POWER] = $urandom_range(0, 100);
      end
      for (int i = 0; i < 7; i++) begin
        write_reg(reg_idx_t'(i), phase_cfg[p][i]);
      end
      settings_used++;
      cur_sp_deg = phase_cfg[p][REG_SP_DEG];
      burst_left = 0;
      repeat (PHASE_ITEMS) begin
        pace();
        rd = random_reading(cur_sp_deg);
        offer(rd.whole, rd.half, rd.neg, rd.sen, rd.low, rd.high);
      end
      settle();
    end

    // Let any stray result show up
    repeat (30) @(negedge clk);

    $display("Covered %0d readings (%0d directed), %0d results, %0d register settings, %0d writes",
             readings_sent, directed_sent, results_seen, settings_used + 1, reg_writes);
    $display("Included alarm overrides, manual mode, band edges, negative readings, %0d-cycle stall",
             HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== heater_power_slew_controller.f =====
+incdir+hdl
hdl/hpsc_pkg.sv
hdl/hpsc_cfg.sv
hdl/hpsc_div.sv
hdl/heater_power_slew_controller.sv
hdl/hpsc_chk.sv
tb/sv/power_checker.sv
tb/sv/testbench.sv
